FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the line rasterizer RTL
// Concurrent checks clocked on the rising edge, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check gated off while reset is asserted
`define MLR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// check that also holds during reset
`define MLR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: sv/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Types and constants shared by the midpoint line rasterizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlr_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned DecW   = 16;
  localparam int unsigned LeftW  = 13;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } mlr_cmd_e;

  // classified item handed from the front end to the back end
  typedef struct packed {
    mlr_cmd_e            cmd;
    logic [CoordW-1:0]   sx;
    logic [CoordW-1:0]   sy;
    logic                x_major;
    logic                major_neg;
    logic                minor_neg;
    logic [CoordW-1:0]   maj;
    logic [CoordW-1:0]   mnr;
  } mlr_item_t;

  typedef struct packed {
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic                visible;
    logic                last;
  } mlr_pixel_t;

endpackage

`default_nettype wire

FILE: sv/mlr_fifo.sv
// ----------------------------------------------------------------------------
// mlr_fifo
// Small register FIFO used between the rasterizer stages and at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mlr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2   // at least 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr_en, rd_en;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `MLR_ASSERT_ALWAYS(a_count_bound, clk_i, !rst_ni || count_q <= CntW'(DEPTH))
  `MLR_ASSERT(a_count_up, clk_i, rst_ni, (wr_en && !rd_en) |=> count_q == $past(count_q) + 1'b1)
  `MLR_ASSERT(a_ptr_gap, clk_i, rst_ni, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))

endmodule

`default_nettype wire

FILE: sv/mlr_front.sv
// ----------------------------------------------------------------------------
// mlr_front
// Classifies incoming items: for a load, finds the major axis and directions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlr_front (
  input  wire logic             cmd_i,
  input  wire logic [11:0]      start_x_i,
  input  wire logic [11:0]      start_y_i,
  input  wire logic [11:0]      end_x_i,
  input  wire logic [11:0]      end_y_i,
  output mlr_pkg::mlr_item_t    item_o
);

  logic signed [12:0] dx, dy;
  logic        [12:0] ax, ay;
  logic               x_major;

  assign dx = $signed({end_x_i[11], end_x_i}) - $signed({start_x_i[11], start_x_i});
  assign dy = $signed({end_y_i[11], end_y_i}) - $signed({start_y_i[11], start_y_i});
  assign ax = dx[12] ? 13'(-dx) : 13'(dx);
  assign ay = dy[12] ? 13'(-dy) : 13'(dy);

  // ties go to x
  assign x_major = (ax >= ay);

  always_comb begin
    item_o.cmd       = mlr_pkg::mlr_cmd_e'(cmd_i);
    item_o.sx        = start_x_i;
    item_o.sy        = start_y_i;
    item_o.x_major   = x_major;
    item_o.major_neg = x_major ? dx[12] : dy[12];
    item_o.minor_neg = x_major ? dy[12] : dx[12];
    item_o.maj       = x_major ? ax[11:0] : ay[11:0];
    item_o.mnr       = x_major ? ay[11:0] : ax[11:0];
  end

endmodule

`default_nettype wire

FILE: sv/mlr_back.sv
// ----------------------------------------------------------------------------
// mlr_back
// Line walker: holds the line state and emits one pixel per step item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mlr_back #(
  parameter int unsigned SCREEN_WIDTH  = 1920,
  parameter int unsigned SCREEN_HEIGHT = 1080
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  mlr_pkg::mlr_item_t     item_i,
  input  wire logic              item_avail_i,
  output logic                   item_take_o,
  output mlr_pkg::mlr_pixel_t    pixel_o,
  output logic                   pixel_push_o,
  input  wire logic              pixel_full_i
);

  localparam logic signed [11:0] XMax = 12'(SCREEN_WIDTH - 1);
  localparam logic signed [11:0] YMax = 12'(SCREEN_HEIGHT - 1);

  logic [11:0] cur_x_q, cur_x_d;
  logic [11:0] cur_y_q, cur_y_d;
  logic [15:0] dec_q, dec_d;
  logic [15:0] inc_major_q, inc_major_d;
  logic [15:0] inc_both_q, inc_both_d;
  logic [12:0] left_q, left_d;
  logic        x_major_q, x_major_d;
  logic        major_neg_q, major_neg_d;
  logic        minor_neg_q, minor_neg_d;

  logic        is_load, is_step;
  logic [15:0] two_mnr;
  logic        step_minor;
  logic [11:0] x_major_step, y_major_step, x_minor_step, y_minor_step;

  assign item_take_o  = item_avail_i && !pixel_full_i;
  assign is_load      = item_take_o && (item_i.cmd == mlr_pkg::CMD_LOAD);
  assign is_step      = item_take_o && (item_i.cmd == mlr_pkg::CMD_STEP);
  assign pixel_push_o = is_step && (left_q != '0);

  assign two_mnr    = {3'b000, item_i.mnr, 1'b0};
  assign step_minor = !dec_q[15];

  assign x_major_step = major_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
  assign y_major_step = major_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
  assign x_minor_step = minor_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
  assign y_minor_step = minor_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;

  always_comb begin
    pixel_o.x       = cur_x_q;
    pixel_o.y       = cur_y_q;
    pixel_o.visible = ($signed(cur_x_q) >= 12'sd1) && ($signed(cur_x_q) <= XMax) &&
                      ($signed(cur_y_q) >= 12'sd1) && ($signed(cur_y_q) <= YMax);
    pixel_o.last    = (left_q == 13'd1);
  end

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    dec_d       = dec_q;
    inc_major_d = inc_major_q;
    inc_both_d  = inc_both_q;
    left_d      = left_q;
    x_major_d   = x_major_q;
    major_neg_d = major_neg_q;
    minor_neg_d = minor_neg_q;
    if (is_load) begin
      cur_x_d     = item_i.sx;
      cur_y_d     = item_i.sy;
      dec_d       = two_mnr - {4'b0000, item_i.maj};
      inc_major_d = two_mnr;
      inc_both_d  = two_mnr - {3'b000, item_i.maj, 1'b0};
      left_d      = {1'b0, item_i.maj};
      x_major_d   = item_i.x_major;
      major_neg_d = item_i.major_neg;
      minor_neg_d = item_i.minor_neg;
    end else if (pixel_push_o) begin
      // major axis always moves; minor moves when the midpoint is passed
      if (x_major_q) begin
        cur_x_d = x_major_step;
        if (step_minor) begin
          cur_y_d = y_minor_step;
        end
      end else begin
        cur_y_d = y_major_step;
        if (step_minor) begin
          cur_x_d = x_minor_step;
        end
      end
      dec_d  = dec_q + (step_minor ? inc_both_q : inc_major_q);
      left_d = left_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      dec_q       <= '0;
      inc_major_q <= '0;
      inc_both_q  <= '0;
      left_q      <= '0;
      x_major_q   <= 1'b1;
      major_neg_q <= 1'b0;
      minor_neg_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      dec_q       <= dec_d;
      inc_major_q <= inc_major_d;
      inc_both_q  <= inc_both_d;
      left_q      <= left_d;
      x_major_q   <= x_major_d;
      major_neg_q <= major_neg_d;
      minor_neg_q <= minor_neg_d;
    end
  end

  `MLR_ASSERT(a_load_count, clk_i, rst_ni, is_load |=> left_q == {1'b0, $past(item_i.maj)})
  `MLR_ASSERT(a_step_count, clk_i, rst_ni, pixel_push_o |=> left_q == $past(left_q) - 1'b1)
  `MLR_ASSERT(a_no_take_full, clk_i, rst_ni, pixel_full_i |-> !item_take_o)

endmodule

`default_nettype wire

FILE: sv/midpoint_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_unit
// Midpoint line rasterizer with queue-style command input and pixel output.
// ----------------------------------------------------------------------------
// Input channel: an item is taken on a rising edge with push high and full
// low. cmd_i = 0 loads a line from (start_x_i, start_y_i) to (end_x_i,
// end_y_i); cmd_i = 1 asks for the next pixel of the current line.
// Output channel: while empty is low the oldest pixel sits on pixel_x_o,
// pixel_y_o, visible_o and last_pixel_o; it is taken on an edge with pop high.
// The start point is the first pixel, the end point is never drawn, and a
// step with no pixels left yields nothing. Loads yield nothing either.
// Throughput: one item per cycle while the output queue is not full, set by
// the back end's combinational add-and-compare step. Path: a step lands in
// the command queue, then the line walker writes its pixel into the output
// queue, from which it shows on the output.
// Reset clears both queues and the line state; no line is in progress.
// If the receiver stops popping, the two-entry output queue fills, the line
// walker holds, the two-entry command queue fills and full goes high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midpoint_line_rasterizer_unit #(
  parameter int unsigned SCREEN_WIDTH  = 1920,
  parameter int unsigned SCREEN_HEIGHT = 1080
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd_i,
  input  wire logic [11:0] start_x_i,
  input  wire logic [11:0] start_y_i,
  input  wire logic [11:0] end_x_i,
  input  wire logic [11:0] end_y_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [11:0]      pixel_x_o,
  output logic [11:0]      pixel_y_o,
  output logic             visible_o,
  output logic             last_pixel_o
);

  localparam int unsigned ItemW  = $bits(mlr_pkg::mlr_item_t);
  localparam int unsigned PixelW = $bits(mlr_pkg::mlr_pixel_t);

  mlr_pkg::mlr_item_t  front_item, back_item;
  mlr_pkg::mlr_pixel_t back_pixel, out_pixel;
  logic                cmdq_empty, item_take;
  logic                pix_push, pix_full;

  mlr_front u_front (
    .cmd_i     (cmd_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .item_o    (front_item)
  );

  mlr_fifo #(
    .WIDTH (ItemW),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_item),
    .full_o  (full),
    .pop_i   (item_take),
    .rdata_o (back_item),
    .empty_o (cmdq_empty)
  );

  mlr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_avail_i (!cmdq_empty),
    .item_take_o  (item_take),
    .pixel_o      (back_pixel),
    .pixel_push_o (pix_push),
    .pixel_full_i (pix_full)
  );

  mlr_fifo #(
    .WIDTH (PixelW),
    .DEPTH (2)
  ) u_pix_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pix_push),
    .wdata_i (back_pixel),
    .full_o  (pix_full),
    .pop_i   (pop),
    .rdata_o (out_pixel),
    .empty_o (empty)
  );

  assign pixel_x_o    = out_pixel.x;
  assign pixel_y_o    = out_pixel.y;
  assign visible_o    = out_pixel.visible;
  assign last_pixel_o = out_pixel.last;

endmodule

`default_nettype wire
